// ===== design/utf8_byte_stream_decoder_assert.svh =====
// Assertion macros for the UTF-8 byte stream decoder.
// Used by the top level through `include; no other dependencies.
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U8D_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8d assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8d assertion failed: next-cycle implication");

`endif

// ===== design/u8d_pkg.sv =====
// Package for the UTF-8 byte stream decoder: widths, status codes, result type.
// No dependencies; used by u8d_step and utf8_byte_stream_decoder.
package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_W = 31;
    localparam int unsigned REM_W  = 3;
    localparam int unsigned CONT_W = 6;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    // One decoded result
    typedef struct packed {
        logic [CODE_W-1:0] codepoint;
        t_status           status;
        logic              final_res;
    } t_result;

endpackage

// ===== design/u8d_step.sv =====
// Combinational decode step: one byte against the current sequence state.
// Depends on u8d_pkg.
module u8d_step (
    input  logic [u8d_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last_byte,
    input  logic [u8d_pkg::REM_W-1:0]  i_remaining,
    input  logic [u8d_pkg::CODE_W-1:0] i_partial,
    output logic [u8d_pkg::REM_W-1:0]  o_remaining,
    output logic [u8d_pkg::CODE_W-1:0] o_partial,
    output logic                       o_res_valid,
    output u8d_pkg::t_result           o_res
);

    logic [u8d_pkg::REM_W-1:0]  rem_dec;
    logic [u8d_pkg::CODE_W-1:0] shifted;
    logic [u8d_pkg::REM_W-1:0]  need;
    logic [u8d_pkg::CODE_W-1:0] lead_bits;
    logic                       bad_lead;

    assign rem_dec = i_remaining - u8d_pkg::REM_W'(1);
    assign shifted = {i_partial[u8d_pkg::CODE_W-u8d_pkg::CONT_W-1:0],
                      i_data_byte[u8d_pkg::CONT_W-1:0]};

    // Lead byte classification: continuation count and payload bits
    always_comb begin
        need      = '0;
        lead_bits = '0;
        bad_lead  = 1'b0;
        case (i_data_byte) inside
            8'b0???????: begin
                lead_bits = u8d_pkg::CODE_W'(i_data_byte);
            end
            8'b110?????: begin
                need      = 3'd1;
                lead_bits = u8d_pkg::CODE_W'(i_data_byte[4:0]);
            end
            8'b1110????: begin
                need      = 3'd2;
                lead_bits = u8d_pkg::CODE_W'(i_data_byte[3:0]);
            end
            8'b11110???: begin
                need      = 3'd3;
                lead_bits = u8d_pkg::CODE_W'(i_data_byte[2:0]);
            end
            8'b111110??: begin
                need      = 3'd4;
                lead_bits = u8d_pkg::CODE_W'(i_data_byte[1:0]);
            end
            8'b1111110?: begin
                need      = 3'd5;
                lead_bits = u8d_pkg::CODE_W'(i_data_byte[0]);
            end
            default: begin
                // stray continuation, 0xFE or 0xFF
                bad_lead = 1'b1;
            end
        endcase
    end

    // Sequence update and result selection
    always_comb begin
        o_remaining         = i_remaining;
        o_partial           = i_partial;
        o_res_valid         = 1'b0;
        o_res.codepoint     = '0;
        o_res.status        = u8d_pkg::ST_OK;
        o_res.final_res     = i_last_byte;
        if (i_remaining != '0) begin
            // continuation: prefix deliberately not checked
            if (rem_dec == '0) begin
                o_remaining     = '0;
                o_partial       = '0;
                o_res_valid     = 1'b1;
                o_res.codepoint = shifted;
            end else if (i_last_byte) begin
                o_remaining  = '0;
                o_partial    = '0;
                o_res_valid  = 1'b1;
                o_res.status = u8d_pkg::ST_TRUNCATED;
            end else begin
                o_remaining = rem_dec;
                o_partial   = shifted;
            end
        end else if (bad_lead) begin
            o_res_valid  = 1'b1;
            o_res.status = u8d_pkg::ST_BAD_LEAD;
        end else if (need == '0) begin
            o_res_valid     = 1'b1;
            o_res.codepoint = lead_bits;
        end else if (i_last_byte) begin
            o_res_valid  = 1'b1;
            o_res.status = u8d_pkg::ST_TRUNCATED;
        end else begin
            o_remaining = need;
            o_partial   = lead_bits;
        end
    end

endmodule

// ===== design/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder (up to 6-byte sequences, 31-bit codes).
// Depends on u8d_pkg, u8d_step and utf8_byte_stream_decoder_assert.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   input   | in        | i_valid / o_stall  | i_data_byte, i_last_byte
//   result  | out       | o_valid / i_stall  | o_codepoint, o_status, o_final_res
//
// One byte per cycle while o_stall is low; results are registered, not combinational.
// The rate is set by the sequence state registers, which update on every accepted byte.
// Output register plus one skid entry: o_stall rises only when both are full.
// Synchronous active-low reset clears sequence state and both valid flags.
module utf8_byte_stream_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [u8d_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [u8d_pkg::CODE_W-1:0] o_codepoint,
    output logic [1:0]                 o_status,
    output logic                       o_final_res
);

`include "utf8_byte_stream_decoder_assert.svh"

    logic [u8d_pkg::REM_W-1:0]  r_remaining, n_remaining;
    logic [u8d_pkg::CODE_W-1:0] r_partial, n_partial;
    logic                       r_out_valid, n_out_valid;
    logic                       r_skid_valid, n_skid_valid;
    u8d_pkg::t_result           r_out, n_out;
    u8d_pkg::t_result           r_skid, n_skid;

    logic [u8d_pkg::REM_W-1:0]  step_remaining;
    logic [u8d_pkg::CODE_W-1:0] step_partial;
    logic                       step_valid;
    u8d_pkg::t_result           step_res;
    logic                       in_accept;
    logic                       emit;
    logic                       out_take;

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign emit      = in_accept && step_valid;
    assign out_take  = r_out_valid && !i_stall;

    u8d_step u_step (
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_remaining (r_remaining),
        .i_partial   (r_partial),
        .o_remaining (step_remaining),
        .o_partial   (step_partial),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    // Sequence state advances on each accepted request
    always_comb begin
        n_remaining = r_remaining;
        n_partial   = r_partial;
        if (in_accept) begin
            n_remaining = step_remaining;
            n_partial   = step_partial;
        end
    end

    // Output register and skid entry
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = step_res;
                n_out_valid = emit;
            end
        end else if (emit) begin
            n_skid       = step_res;
            n_skid_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining  <= '0;
            r_partial    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_remaining  <= n_remaining;
            r_partial    <= n_partial;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid     = r_out_valid;
    assign o_codepoint = r_out.codepoint;
    assign o_status    = r_out.status;
    assign o_final_res = r_out.final_res;

    // Checks
    `U8D_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `U8D_ASSERT_IMPLY(a_rem_range, i_clk, i_rst_n, 1'b1, r_remaining <= 3'd5)
    `U8D_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, in_accept && i_last_byte, r_remaining == '0)
    `U8D_ASSERT_IMPLY(a_error_zero_code, i_clk, i_rst_n, o_valid && (o_status != u8d_pkg::ST_OK), o_codepoint == '0)
    `U8D_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_stall, o_valid && !r_skid_valid)

endmodule

// ===== tb/utf8_byte_stream_decoder_checker.sv =====
// Scoreboard for the UTF-8 byte stream decoder: predicts each result from accepted requests.
// Depends on u8d_pkg; instantiated beside the block by tb_utf8_byte_stream_decoder.
module utf8_byte_stream_decoder_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_stall,
    input  logic [u8d_pkg::BYTE_W-1:0] i_req_byte,
    input  logic                       i_req_last,
    input  logic                       i_res_valid,
    input  logic                       i_res_stall,
    input  logic [u8d_pkg::CODE_W-1:0] i_res_codepoint,
    input  logic [1:0]                 i_res_status,
    input  logic                       i_res_final,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Decoder state as the predictor sees it
    logic [u8d_pkg::REM_W-1:0]  cont_left;
    logic [u8d_pkg::CODE_W-1:0] code_acc;
    u8d_pkg::t_result           decoded_q[$];
    int                         fails;

    // Work out what one accepted byte produces, if anything
    task automatic decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b, input logic fin);
        u8d_pkg::t_result           r;
        logic                       emit;
        logic [u8d_pkg::REM_W-1:0]  need;
        logic [u8d_pkg::CODE_W-1:0] lead_bits;
        r         = '0;
        emit      = 1'b0;
        need      = '0;
        lead_bits = '0;
        if (cont_left != 0) begin
            // any byte counts as a continuation here, prefix unchecked
            code_acc  = {code_acc[u8d_pkg::CODE_W-u8d_pkg::CONT_W-1:0],
                         b[u8d_pkg::CONT_W-1:0]};
            cont_left = cont_left - u8d_pkg::REM_W'(1);
            if (cont_left == 0) begin
                r.codepoint = code_acc;
                r.status    = u8d_pkg::ST_OK;
                r.final_res = fin;
                code_acc    = '0;
                emit        = 1'b1;
            end else if (fin) begin
                cont_left   = '0;
                code_acc    = '0;
                r.status    = u8d_pkg::ST_TRUNCATED;
                r.final_res = 1'b1;
                emit        = 1'b1;
            end
        end else if (!b[7]) begin
            r.codepoint = u8d_pkg::CODE_W'(b);
            r.status    = u8d_pkg::ST_OK;
            r.final_res = fin;
            emit        = 1'b1;
        end else begin
            casez (b)
                8'b110?????: begin
                    need = 3'd1; lead_bits = u8d_pkg::CODE_W'(b[4:0]);
                end
                8'b1110????: begin
                    need = 3'd2; lead_bits = u8d_pkg::CODE_W'(b[3:0]);
                end
                8'b11110???: begin
                    need = 3'd3; lead_bits = u8d_pkg::CODE_W'(b[2:0]);
                end
                8'b111110??: begin
                    need = 3'd4; lead_bits = u8d_pkg::CODE_W'(b[1:0]);
                end
                8'b1111110?: begin
                    need = 3'd5; lead_bits = u8d_pkg::CODE_W'(b[0]);
                end
                default:     need = 3'd0;
            endcase
            if (need == 0) begin
                // stray continuation, 0xFE or 0xFF as lead
                r.status    = u8d_pkg::ST_BAD_LEAD;
                r.final_res = fin;
                emit        = 1'b1;
            end else if (fin) begin
                r.status    = u8d_pkg::ST_TRUNCATED;
                r.final_res = 1'b1;
                emit        = 1'b1;
            end else begin
                cont_left = need;
                code_acc  = lead_bits;
            end
        end
        if (emit)
            decoded_q.push_back(r);
    endtask

    task automatic report(input string what, input logic [u8d_pkg::CODE_W-1:0] exp_v,
                          input logic [u8d_pkg::CODE_W-1:0] got_v);
        fails = fails + 1;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
    endtask

    // Watch both channels; new request first, then compare the result taken
    always @(posedge i_clk) begin
        u8d_pkg::t_result e;
        if (!i_rst_n) begin
            cont_left = '0;
            code_acc  = '0;
            decoded_q.delete();
        end else begin
            if (i_req_valid && !i_req_stall)
                decode_byte(i_req_byte, i_req_last);
            if (i_res_valid && !i_res_stall) begin
                if (decoded_q.size() == 0) begin
                    fails = fails + 1;
                    $display("%0t: unexpected result, expected none, got %0h/%0d/%0d",
                             $time, i_res_codepoint, i_res_status, i_res_final);
                end else begin
                    e = decoded_q.pop_front();
                    if (e.codepoint !== i_res_codepoint)
                        report("codepoint", e.codepoint, i_res_codepoint);
                    if (e.status !== i_res_status)
                        report("status", u8d_pkg::CODE_W'(e.status),
                               u8d_pkg::CODE_W'(i_res_status));
                    if (e.final_res !== i_res_final)
                        report("final flag", u8d_pkg::CODE_W'(e.final_res),
                               u8d_pkg::CODE_W'(i_res_final));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= decoded_q.size();
    end

endmodule

// ===== tb/tb_utf8_byte_stream_decoder.sv =====
// Testbench top for the UTF-8 byte stream decoder: clock, reset, byte stimulus and verdict.
// Depends on u8d_pkg, utf8_byte_stream_decoder and utf8_byte_stream_decoder_checker.
module tb_utf8_byte_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic [u8d_pkg::BYTE_W-1:0] i_data_byte = '0;
    logic                       i_last_byte = 1'b0;
    logic                       i_stall     = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [u8d_pkg::CODE_W-1:0] o_codepoint;
    logic [1:0]                 o_status;
    logic                       o_final_res;

    int fail_count;
    int pending;
    int sent          = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    utf8_byte_stream_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_codepoint (o_codepoint),
        .o_status    (o_status),
        .o_final_res (o_final_res)
    );

    utf8_byte_stream_decoder_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_byte      (i_data_byte),
        .i_req_last      (i_last_byte),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_res_codepoint (o_codepoint),
        .i_res_status    (o_status),
        .i_res_final     (o_final_res),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one request, with random idle cycles ahead of it, and wait for it to be taken
    task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        do @(posedge i_clk); while (o_stall);
        sent = sent + 1;
    endtask

    // Stop offering until every predicted result has come out
    task automatic drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly well-formed sequences of random length and content, some noise
    task automatic send_random_seq;
        int          n;
        logic [31:0] v;
        logic [7:0]  b;
        v = $urandom();
        if ($urandom_range(0, 99) < 15) begin
            send_byte(v[7:0], $urandom_range(0, 15) == 0);
        end else begin
            n = $urandom_range(1, 6);
            case (n)
                1:       b = {1'b0, v[6:0]};
                2:       b = {3'b110, v[4:0]};
                3:       b = {4'b1110, v[3:0]};
                4:       b = {5'b11110, v[2:0]};
                5:       b = {6'b111110, v[1:0]};
                default: b = {7'b1111110, v[0]};
            endcase
            send_byte(b, $urandom_range(0, 19) == 0);
            for (int k = 1; k < n; k++) begin
                v = $urandom();
                // occasional continuation with a wrong prefix
                if ($urandom_range(0, 9) == 0)
                    b = v[7:0];
                else
                    b = {2'b10, v[5:0]};
                send_byte(b, $urandom_range(0, 19) == 0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender rarely idles, receiver often stalls
        send_idle_pct = 10;
        recv_idle_pct = 55;

        // Directed: ASCII extremes, every sequence length, bad leads, truncation
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        repeat (4) send_byte(8'h80, 1'b0);
        // largest codepoint, all payload bits set
        send_byte(8'hFD, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hC3, 1'b1);
        // continuation without the 10 prefix, then cut short by the last byte
        send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b1);

        while (sent < 530) send_random_seq();
        drain();

        // Phase two: sender often idles, receiver rarely stalls
        send_idle_pct = 55;
        recv_idle_pct = 10;
        while (sent < 1030) send_random_seq();
        drain();

        // Phase three: no idling; a long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs = hold_reqs + 1;
        repeat (60) send_byte(8'($urandom_range(0, 127)), 1'b0);
        while (sent < 1530) send_random_seq();

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/u8d_pkg.sv
design/u8d_step.sv
design/utf8_byte_stream_decoder.sv
tb/utf8_byte_stream_decoder_checker.sv
tb/tb_utf8_byte_stream_decoder.sv
